// ===== hdl/rhc_pkg.sv =====
// Package with the word types, pipeline record and constants of the colour converter.
`default_nettype none
package rhc_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned FieldW   = 17;
  localparam int unsigned RemW     = 20;
  localparam int unsigned DivSteps = 17;
  localparam logic [FieldW-1:0] One = FieldW'(1) << FracBits;

  localparam logic DirRgbToHsv = 1'b0;
  localparam logic DirHsvToRgb = 1'b1;
  localparam logic AddrDirection = 1'b0;

  typedef struct packed {
    logic [FieldW-1:0] comp_a;
    logic [FieldW-1:0] comp_b;
    logic [FieldW-1:0] comp_c;
  } rhc_in_t;

  typedef struct packed {
    logic [FieldW-1:0] out_a;
    logic [FieldW-1:0] out_b;
    logic [FieldW-1:0] out_c;
  } rhc_out_t;

  typedef struct packed {
    logic              vld;
    logic              dir;
    logic [RemW-1:0]   h_rem;
    logic [RemW-1:0]   h_div;
    logic              h_nb;
    logic [FieldW-1:0] h_q;
    logic [RemW-1:0]   s_rem;
    logic [RemW-1:0]   s_div;
    logic              s_nb;
    logic [FieldW-1:0] s_q;
    logic [FieldW-1:0] val;
    logic              mx_zero;
    logic              d_zero;
    logic [FieldW-1:0] r0;
    logic [FieldW-1:0] r1;
    logic [FieldW-1:0] r2;
  } rhc_pipe_t;

endpackage
`default_nettype wire

// ===== hdl/rhc_front.sv =====
// Front stages: input saturation, channel sort, sector numerator and the RGB reconstruction.
`default_nettype none
module rhc_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire logic              dir_i,
  input  wire rhc_pkg::rhc_in_t  in_i,
  output rhc_pkg::rhc_pipe_t     pipe_o
);

  localparam int unsigned W = rhc_pkg::FieldW;
  localparam int unsigned R = rhc_pkg::RemW;

  // Stage one: saturated inputs.
  logic         v1_q, d1_q;
  logic [W-1:0] a1_q, b1_q, c1_q;

  function automatic logic [W-1:0] sat_one(input logic [W-1:0] x);
    return (x > rhc_pkg::One) ? rhc_pkg::One : x;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q <= dir_i;
    a1_q <= sat_one(in_i.comp_a);
    b1_q <= sat_one(in_i.comp_b);
    c1_q <= sat_one(in_i.comp_c);
  end

  // Stage two: sort, numerator, divisors; first product and hue times six.
  logic [W-1:0]       mx_d, mn_d, df_d;
  logic signed [21:0] n_d;
  logic [R-1:0]       nn_d, six_d;
  logic [2*W-1:0]     p1_d;
  logic [R-1:0]       hp_d;

  always_comb begin
    mx_d = a1_q;
    if (b1_q > mx_d) begin
      mx_d = b1_q;
    end
    if (c1_q > mx_d) begin
      mx_d = c1_q;
    end
    mn_d = a1_q;
    if (b1_q < mn_d) begin
      mn_d = b1_q;
    end
    if (c1_q < mn_d) begin
      mn_d = c1_q;
    end
    df_d = mx_d - mn_d;
    if (mx_d == a1_q) begin
      n_d = $signed({5'b0, b1_q}) - $signed({5'b0, c1_q});
    end else if (mx_d == b1_q) begin
      n_d = $signed({4'b0, df_d, 1'b0}) + $signed({5'b0, c1_q}) - $signed({5'b0, a1_q});
    end else begin
      n_d = $signed({3'b0, df_d, 2'b0}) + $signed({5'b0, a1_q}) - $signed({5'b0, b1_q});
    end
    six_d = {1'b0, df_d, 2'b0} + {2'b0, df_d, 1'b0};
    if (n_d < 0) begin
      n_d = n_d + $signed({2'b0, six_d});
    end
    nn_d = R'(n_d);
    p1_d = {{W{1'b0}}, b1_q} * {{W{1'b0}}, c1_q};
    hp_d = {1'b0, a1_q, 2'b0} + {2'b0, a1_q, 1'b0};
  end

  logic         v2_q, d2_q;
  logic [W-1:0] mx2_q, df2_q, v2v_q;
  logic [R-1:0] nn2_q, six2_q, hp2_q;
  logic         mz2_q;
  logic [2*W-1:0] p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d2_q   <= d1_q;
    mx2_q  <= mx_d;
    mz2_q  <= (mx_d == '0);
    df2_q  <= df_d;
    nn2_q  <= nn_d;
    six2_q <= six_d;
    p1_q   <= p1_d;
    hp2_q  <= hp_d;
    v2v_q  <= c1_q;
  end

  // Stage three: chroma, minimum, distance to the sector centre, second product.
  logic [W-1:0]   cd_d, cmn_d, m_d, dist_d, wt_d;
  logic [2*W-1:0] p2_d;

  always_comb begin
    cd_d  = p1_q[rhc_pkg::FracBits +: W];
    cmn_d = v2v_q - cd_d;
    m_d   = hp2_q[W-1:0];
    dist_d = (m_d >= rhc_pkg::One) ? (m_d - rhc_pkg::One) : (rhc_pkg::One - m_d);
    wt_d  = rhc_pkg::One - dist_d;
    p2_d  = {{W{1'b0}}, cd_d} * {{W{1'b0}}, wt_d};
  end

  logic         v3_q, d3_q, mz3_q;
  logic [W-1:0] mx3_q, df3_q, cd3_q, cmn3_q, v3v_q;
  logic [R-1:0] nn3_q, six3_q, hp3_q;
  logic [2*W-1:0] p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d3_q   <= d2_q;
    mz3_q  <= mz2_q;
    mx3_q  <= mx2_q;
    df3_q  <= df2_q;
    nn3_q  <= nn2_q;
    six3_q <= six2_q;
    hp3_q  <= hp2_q;
    cd3_q  <= cd_d;
    cmn3_q <= cmn_d;
    v3v_q  <= v2v_q;
    p2_q   <= p2_d;
  end

  // Stage four: sector selection and divider set-up.
  rhc_pkg::rhc_pipe_t p_d;
  logic [W-1:0] lo, hi, mid;

  always_comb begin
    lo  = cmn3_q;
    hi  = cd3_q + cmn3_q;
    mid = p2_q[rhc_pkg::FracBits +: W] + cmn3_q;
    p_d = '0;
    p_d.vld     = v3_q;
    p_d.dir     = d3_q;
    p_d.h_rem   = nn3_q >> 1;
    p_d.h_nb    = nn3_q[0];
    p_d.h_div   = six3_q;
    p_d.s_rem   = R'(df3_q >> 1);
    p_d.s_nb    = df3_q[0];
    p_d.s_div   = R'(mx3_q);
    p_d.val     = mx3_q;
    p_d.mx_zero = mz3_q;
    p_d.d_zero  = (df3_q == '0);
    if (cd3_q == '0) begin
      p_d.r0 = v3v_q;
      p_d.r1 = v3v_q;
      p_d.r2 = v3v_q;
    end else if (hp3_q >= R'(4 * rhc_pkg::One)) begin
      if (hp3_q <= R'(5 * rhc_pkg::One)) begin
        p_d.r0 = mid; p_d.r1 = lo; p_d.r2 = hi;
      end else begin
        p_d.r0 = hi; p_d.r1 = lo; p_d.r2 = mid;
      end
    end else if (hp3_q >= R'(2 * rhc_pkg::One)) begin
      if (hp3_q <= R'(3 * rhc_pkg::One)) begin
        p_d.r0 = lo; p_d.r1 = hi; p_d.r2 = mid;
      end else begin
        p_d.r0 = lo; p_d.r1 = mid; p_d.r2 = hi;
      end
    end else begin
      if (hp3_q <= R'(rhc_pkg::One)) begin
        p_d.r0 = hi; p_d.r1 = mid; p_d.r2 = lo;
      end else begin
        p_d.r0 = mid; p_d.r1 = hi; p_d.r2 = lo;
      end
    end
  end

  logic                                  vld_q;
  logic [$bits(rhc_pkg::rhc_pipe_t)-2:0] body_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= p_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    body_q <= p_d[$bits(rhc_pkg::rhc_pipe_t)-2:0];
  end

  assign pipe_o = {vld_q, body_q};

endmodule
`default_nettype wire

// ===== hdl/rhc_div_step.sv =====
// One registered restoring step of the hue and saturation dividers.
`default_nettype none
module rhc_div_step (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire rhc_pkg::rhc_pipe_t  pipe_i,
  output rhc_pkg::rhc_pipe_t       pipe_o
);

  localparam int unsigned R = rhc_pkg::RemW;

  rhc_pkg::rhc_pipe_t p_d;
  logic [R-1:0] hs, ss;
  logic                                  vld_q;
  logic [$bits(rhc_pkg::rhc_pipe_t)-2:0] body_q;

  always_comb begin
    p_d = pipe_i;
    hs  = {pipe_i.h_rem[R-2:0], pipe_i.h_nb};
    ss  = {pipe_i.s_rem[R-2:0], pipe_i.s_nb};
    p_d.h_nb = 1'b0;
    p_d.s_nb = 1'b0;
    if (hs >= pipe_i.h_div) begin
      p_d.h_rem = hs - pipe_i.h_div;
      p_d.h_q   = {pipe_i.h_q[rhc_pkg::FieldW-2:0], 1'b1};
    end else begin
      p_d.h_rem = hs;
      p_d.h_q   = {pipe_i.h_q[rhc_pkg::FieldW-2:0], 1'b0};
    end
    if (ss >= pipe_i.s_div) begin
      p_d.s_rem = ss - pipe_i.s_div;
      p_d.s_q   = {pipe_i.s_q[rhc_pkg::FieldW-2:0], 1'b1};
    end else begin
      p_d.s_rem = ss;
      p_d.s_q   = {pipe_i.s_q[rhc_pkg::FieldW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= p_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    body_q <= p_d[$bits(rhc_pkg::rhc_pipe_t)-2:0];
  end

  assign pipe_o = {vld_q, body_q};

endmodule
`default_nettype wire

// ===== hdl/rgb_hsv_conversion.sv =====
// Top level of the pipelined RGB and HSV colour converter with its register port.
// A word is taken on every clock edge where start_i is high; busy_o is always low, so one
// pixel per cycle is sustained. Each result appears on res_o with done_o high for one cycle,
// once its word has passed through four front stages, seventeen divider stages (one quotient
// bit per stage) and the output register. Results leave in input order and
// cannot be held off. The direction register should be written only while no word is in flight.
`default_nettype none
module rgb_hsv_conversion (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire rhc_pkg::rhc_in_t  in_i,
  output logic                   done_o,
  output rhc_pkg::rhc_out_t      res_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic dir_q;

  assign pready = 1'b1;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= rhc_pkg::DirRgbToHsv;
    end else if (psel && penable && pwrite && (paddr[2] == rhc_pkg::AddrDirection)) begin
      dir_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == rhc_pkg::AddrDirection) ? {31'b0, dir_q} : 32'b0;

  rhc_pkg::rhc_pipe_t pipe [rhc_pkg::DivSteps+1];

  rhc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start_i),
    .dir_i  (dir_q),
    .in_i   (in_i),
    .pipe_o (pipe[0])
  );

  for (genvar k = 0; k < rhc_pkg::DivSteps; k++) begin : g_div
    rhc_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .pipe_i (pipe[k]),
      .pipe_o (pipe[k+1])
    );
  end

  rhc_pkg::rhc_pipe_t last;
  rhc_pkg::rhc_out_t  res_d, res_q;
  logic               done_q;

  assign last = pipe[rhc_pkg::DivSteps];

  always_comb begin
    if (last.dir == rhc_pkg::DirHsvToRgb) begin
      res_d.out_a = last.r0;
      res_d.out_b = last.r1;
      res_d.out_c = last.r2;
    end else begin
      res_d.out_a = last.d_zero ? '0 : last.h_q;
      res_d.out_b = last.mx_zero ? '0 : last.s_q;
      res_d.out_c = last.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== hdl/rhc_checker.sv =====
// Port-level checker of the colour converter and its binding to the top level.
`default_nettype none
module rhc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               done_o,
  input wire rhc_pkg::rhc_out_t  res_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("The converter reported busy.");

  a_word_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> ##22 done_o)
    else $error("A word was taken but its result did not appear in time.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |-> ##22 !done_o)
    else $error("A result appeared without a word.");

  a_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.out_a <= rhc_pkg::One) && (res_o.out_b <= rhc_pkg::One)
               && (res_o.out_c <= rhc_pkg::One))
    else $error("A result component exceeds one.");

endmodule

bind rgb_hsv_conversion rhc_checker u_rhc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the RGB and HSV colour converter.
`timescale 1ns / 1ps

class hsv_scoreboard;
  rhc_pkg::rhc_out_t pending_px[$];
  bit                dir_setting;
  int                n_errors;

  function rhc_pkg::rhc_out_t convert(rhc_pkg::rhc_in_t w);
    longint unsigned one, a, b, c, mx, mn, diff, hue, sat, hp, m, span, x, lo, hi, mid;
    longint          n, d;
    rhc_pkg::rhc_out_t o;
    one = 64'd1 << rhc_pkg::FracBits;
    a = (w.comp_a > one) ? one : w.comp_a;
    b = (w.comp_b > one) ? one : w.comp_b;
    c = (w.comp_c > one) ? one : w.comp_c;
    if (dir_setting == rhc_pkg::DirRgbToHsv) begin
      mx = a; mn = a; hue = 0; sat = 0;
      if (b > mx) mx = b;
      if (c > mx) mx = c;
      if (b < mn) mn = b;
      if (c < mn) mn = c;
      diff = mx - mn;
      if (mx != 0) sat = (diff << rhc_pkg::FracBits) / mx;
      if (diff != 0) begin
        d = diff;
        if (mx == a) n = longint'(b) - longint'(c);
        else if (mx == b) n = 2 * d + longint'(c) - longint'(a);
        else n = 4 * d + longint'(a) - longint'(b);
        if (n < 0) n += 6 * d;
        hue = (longint'(n) << rhc_pkg::FracBits) / (6 * diff);
      end
      o.out_a = hue[16:0]; o.out_b = sat[16:0]; o.out_c = mx[16:0];
    end else begin
      diff = (b * c) >> rhc_pkg::FracBits;
      mn = c - diff;
      if (diff == 0) begin
        o.out_a = c[16:0]; o.out_b = c[16:0]; o.out_c = c[16:0];
      end else begin
        hp = 6 * a;
        m = hp % (2 * one);
        span = (m >= one) ? m - one : one - m;
        x = (diff * (one - span)) >> rhc_pkg::FracBits;
        lo = mn; hi = diff + mn; mid = x + mn;
        if (hp >= 4 * one) begin
          if (hp <= 5 * one) o = {mid[16:0], lo[16:0], hi[16:0]};
          else o = {hi[16:0], lo[16:0], mid[16:0]};
        end else if (hp >= 2 * one) begin
          if (hp <= 3 * one) o = {lo[16:0], hi[16:0], mid[16:0]};
          else o = {lo[16:0], mid[16:0], hi[16:0]};
        end else begin
          if (hp <= one) o = {hi[16:0], mid[16:0], lo[16:0]};
          else o = {mid[16:0], hi[16:0], lo[16:0]};
        end
      end
    end
    return o;
  endfunction

  function void note_pixel(rhc_pkg::rhc_in_t w);
    pending_px.push_back(convert(w));
  endfunction

  function void check_pixel(rhc_pkg::rhc_out_t got);
    rhc_pkg::rhc_out_t exp_px;
    if (pending_px.size() == 0) begin
      $error("unexpected word %h", got);
      n_errors++;
      return;
    end
    exp_px = pending_px.pop_front();
    if (got.out_a !== exp_px.out_a) begin
      $error("out_a expected %0d actual %0d", exp_px.out_a, got.out_a);
      n_errors++;
    end
    if (got.out_b !== exp_px.out_b) begin
      $error("out_b expected %0d actual %0d", exp_px.out_b, got.out_b);
      n_errors++;
    end
    if (got.out_c !== exp_px.out_c) begin
      $error("out_c expected %0d actual %0d", exp_px.out_c, got.out_c);
      n_errors++;
    end
  endfunction
endclass

module tb;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  rhc_pkg::rhc_in_t  in_i = '0;
  logic              done_o;
  rhc_pkg::rhc_out_t res_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  hsv_scoreboard px_board = new();
  int          idle_cycles;
  bit          calm;

  rgb_hsv_conversion DUT (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (done_o) px_board.check_pixel(res_o);
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic write_direction(bit dir);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {rhc_pkg::AddrDirection, 2'b00}; pwdata <= {31'd0, dir};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    px_board.dir_setting = dir;
  endtask

  task automatic send_pixel(logic [16:0] a, logic [16:0] b, logic [16:0] c);
    while (!calm && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= '{comp_a: a, comp_b: b, comp_c: c};
    do @(posedge clk_i); while (busy_o);
    px_board.note_pixel(in_i);
  endtask

  function automatic logic [16:0] pick_field();
    case ($urandom_range(9))
      0: return 17'($urandom);
      1: return rhc_pkg::One;
      2: return '0;
      3: return 17'($urandom_range(4));
      default: return 17'($urandom_range(rhc_pkg::One));
    endcase
  endfunction

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (px_board.pending_px.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic random_phase(int count);
    logic [16:0] v;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 3) && (i < count / 2);
      if ($urandom_range(4) == 0) begin
        v = pick_field();
        send_pixel(v, ($urandom_range(1) != 0) ? v : pick_field(), v);
      end else begin
        send_pixel(pick_field(), pick_field(), pick_field());
      end
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    calm = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    send_pixel('0, '0, '0);
    send_pixel(rhc_pkg::One, rhc_pkg::One, rhc_pkg::One);
    send_pixel(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_pixel(rhc_pkg::One, rhc_pkg::One, '0);
    send_pixel('0, rhc_pkg::One, rhc_pkg::One);
    send_pixel(rhc_pkg::One, '0, 17'd1);
    send_pixel(17'd100, '0, 17'd500);
    send_pixel('0, 17'd300, 17'd200);
    send_pixel(17'd1, 17'd2, 17'd3);
    drain();
    write_direction(rhc_pkg::DirHsvToRgb);
    send_pixel('0, rhc_pkg::One, rhc_pkg::One);
    send_pixel(rhc_pkg::One, rhc_pkg::One, rhc_pkg::One);
    send_pixel(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    send_pixel(17'd12345, '0, 17'd40000);
    send_pixel(17'd10922, rhc_pkg::One, rhc_pkg::One);
    send_pixel(17'd21845, rhc_pkg::One, rhc_pkg::One);
    send_pixel(17'd32768, rhc_pkg::One, rhc_pkg::One);
    send_pixel(17'd43690, rhc_pkg::One, rhc_pkg::One);
    send_pixel(17'd54613, rhc_pkg::One, rhc_pkg::One);
    send_pixel(17'd60000, 17'd1, 17'd1);
    send_pixel(17'd5000, 17'd30000, '0);
    drain();
    write_direction(rhc_pkg::DirRgbToHsv);
    random_phase(600);
    write_direction(rhc_pkg::DirHsvToRgb);
    random_phase(600);
    write_direction(rhc_pkg::DirRgbToHsv);
    random_phase(250);
    write_direction(rhc_pkg::DirHsvToRgb);
    random_phase(250);
    if (px_board.n_errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
